>>> sv/calendar_time_offset_adjust_defines.svh
// Assertion macros shared by the checker module of the offset adjuster.
`ifndef CALENDAR_TIME_OFFSET_ADJUST_DEFINES_SVH
`define CALENDAR_TIME_OFFSET_ADJUST_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CTOA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CTOA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ctoa_pkg.sv
`default_nettype none

package ctoa_pkg;

    // Field widths of one beat
    localparam int YearW   = 15;
    localparam int MonthW  = 4;
    localparam int DayW    = 5;
    localparam int HourW   = 5;
    localparam int MinuteW = 6;

    // Configuration port
    localparam int OffHoursW = 6;
    localparam int OffMinW   = 7;
    localparam int CfgIdxW   = 2;
    localparam int CfgDataW  = 7;

    localparam logic [CfgIdxW-1:0] REG_OFFSET_HOURS   = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_OFFSET_MINUTES = 2'd1;

    // Year saturation limits
    localparam logic [YearW-1:0] YearMin = 15'd1601;
    localparam logic [YearW-1:0] YearMax = 15'd30827;

    // Multiplicative inverse of 25 modulo 2**15, and the largest product
    // that belongs to a multiple of 25
    localparam logic [YearW-1:0] Inv25     = 15'd23593;
    localparam logic [YearW-1:0] Div25Max  = 15'd1310;

    // Gregorian leap rule: divisible by 4, and not by 100 unless by 400.
    // Divisibility by 25 uses the exact-division test on the low bits.
    function automatic logic is_leap(input logic [YearW-1:0] year);
        logic [2*YearW-1:0] prod;
        logic               div25;
        prod  = {{YearW{1'b0}}, year} * {{YearW{1'b0}}, Inv25};
        div25 = (prod[YearW-1:0] <= Div25Max);
        return (year[1:0] == 2'b00) && (!div25 || (year[3:0] == 4'b0000));
    endfunction

    // Days in a month; zero for a month code outside 1..12
    function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] month,
                                                  input logic leap);
        logic [DayW-1:0] len;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            4'd2:                                         len = leap ? 5'd29 : 5'd28;
            default:                                      len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

>>> sv/calendar_time_offset_adjust.sv
// Channel | Direction | Handshake          | Payload
// in      | sink      | in_valid/in_stall  | in_year, in_month, in_day, in_hour, in_minute
// out     | source    | out_valid/out_stall| out_year, out_month, out_day, out_hour,
//         |           |                    | out_minute, ok
// cfg     | sink      | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One beat per cycle sustained while out_stall is low; a beat taken passes the
// input register, then the result register, which drives the output.
// All arithmetic sits between the input register and the result register.
// rst_n clears the valid flags and both offsets to zero.
// in_stall rises only when both registers are full and out_stall is high.
// cfg_ready is always high.
`default_nettype none

module calendar_time_offset_adjust
    import ctoa_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [YearW-1:0]     in_year,
    input  wire logic [MonthW-1:0]    in_month,
    input  wire logic [DayW-1:0]      in_day,
    input  wire logic [HourW-1:0]     in_hour,
    input  wire logic [MinuteW-1:0]   in_minute,

    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [YearW-1:0]          out_year,
    output logic [MonthW-1:0]         out_month,
    output logic [DayW-1:0]           out_day,
    output logic [HourW-1:0]          out_hour,
    output logic [MinuteW-1:0]        out_minute,
    output logic                      ok,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CfgIdxW-1:0]   cfg_index,
    input  wire logic [CfgDataW-1:0]  cfg_data
);

    // Configuration registers
    logic signed [OffHoursW-1:0] off_hours_reg;
    logic signed [OffMinW-1:0]   off_minutes_reg;

    // Input register
    logic                 in_valid_reg;
    logic [YearW-1:0]     year_reg;
    logic [MonthW-1:0]    month_reg;
    logic [DayW-1:0]      day_reg;
    logic [HourW-1:0]     hour_reg;
    logic [MinuteW-1:0]   minute_reg;

    // Result register
    logic                 out_valid_reg;
    logic [YearW-1:0]     out_year_reg;
    logic [MonthW-1:0]    out_month_reg;
    logic [DayW-1:0]      out_day_reg;
    logic [HourW-1:0]     out_hour_reg;
    logic [MinuteW-1:0]   out_minute_reg;
    logic                 ok_reg;

    // Next values
    logic [YearW-1:0]     out_year_next;
    logic [MonthW-1:0]    out_month_next;
    logic [DayW-1:0]      out_day_next;
    logic [HourW-1:0]     out_hour_next;
    logic [MinuteW-1:0]   out_minute_next;
    logic                 ok_next;

    logic                 out_hold;
    logic                 advance;
    logic                 take_in;

    // Datapath intermediates
    logic signed [7:0]    min_sum;
    logic signed [2:0]    min_carry;
    logic signed [7:0]    min_rem;
    logic signed [7:0]    hour_sum;
    logic signed [2:0]    hour_carry;
    logic signed [7:0]    hour_rem;
    logic signed [6:0]    day_sum;
    logic signed [6:0]    day_adj;
    logic                 leap;
    logic [DayW-1:0]      dim;
    logic [DayW-1:0]      prev_len;
    logic [MonthW-1:0]    prev_month;
    logic [MonthW-1:0]    month_adj;
    logic signed [1:0]    year_step;
    logic signed [16:0]   year_sum;

    // Handshake: the result register holds while stalled, input register
    // moves whenever the result register can take it
    assign out_hold  = out_valid_reg && out_stall;
    assign advance   = !out_hold;
    assign in_stall  = in_valid_reg && out_hold;
    assign take_in   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Minute: add offset and split by floor division by 60
    always_comb
    begin
        min_sum = $signed({2'b00, minute_reg}) + $signed({off_minutes_reg[OffMinW-1], off_minutes_reg});
        priority if (min_sum < -8'sd60)
        begin
            min_carry = -3'sd2;
            min_rem   = min_sum + 8'sd120;
        end
        else if (min_sum < 8'sd0)
        begin
            min_carry = -3'sd1;
            min_rem   = min_sum + 8'sd60;
        end
        else if (min_sum < 8'sd60)
        begin
            min_carry = 3'sd0;
            min_rem   = min_sum;
        end
        else if (min_sum < 8'sd120)
        begin
            min_carry = 3'sd1;
            min_rem   = min_sum - 8'sd60;
        end
        else
        begin
            min_carry = 3'sd2;
            min_rem   = min_sum - 8'sd120;
        end
    end

    // Hour: add offset and minute carry, split by floor division by 24
    always_comb
    begin
        hour_sum = $signed({3'b000, hour_reg})
                 + $signed({{2{off_hours_reg[OffHoursW-1]}}, off_hours_reg})
                 + $signed({{5{min_carry[2]}}, min_carry});
        priority if (hour_sum < -8'sd24)
        begin
            hour_carry = -3'sd2;
            hour_rem   = hour_sum + 8'sd48;
        end
        else if (hour_sum < 8'sd0)
        begin
            hour_carry = -3'sd1;
            hour_rem   = hour_sum + 8'sd24;
        end
        else if (hour_sum < 8'sd24)
        begin
            hour_carry = 3'sd0;
            hour_rem   = hour_sum;
        end
        else if (hour_sum < 8'sd48)
        begin
            hour_carry = 3'sd1;
            hour_rem   = hour_sum - 8'sd24;
        end
        else
        begin
            hour_carry = 3'sd2;
            hour_rem   = hour_sum - 8'sd48;
        end
    end

    // Day, month, year: one borrow or carry, month wrap, year clamp
    always_comb
    begin
        leap       = is_leap(year_reg);
        dim        = month_len(month_reg, leap);
        prev_month = (month_reg == 4'd1) ? 4'd12 : month_reg - 4'd1;
        prev_len   = month_len(prev_month, leap);
        day_sum    = $signed({2'b00, day_reg}) + $signed({{4{hour_carry[2]}}, hour_carry});
        year_step  = 2'sd0;

        priority if (day_sum < 7'sd1)
        begin
            day_adj   = day_sum + $signed({2'b00, prev_len});
            month_adj = prev_month;
            if (month_reg == 4'd1)
            begin
                year_step = -2'sd1;
            end
        end
        else if (day_sum > $signed({2'b00, dim}))
        begin
            day_adj   = day_sum - $signed({2'b00, dim});
            month_adj = (month_reg == 4'd12) ? 4'd1 : month_reg + 4'd1;
            if (month_reg == 4'd12)
            begin
                year_step = 2'sd1;
            end
        end
        else
        begin
            day_adj   = day_sum;
            month_adj = month_reg;
        end

        year_sum = $signed({2'b00, year_reg}) + $signed({{15{year_step[1]}}, year_step});

        out_minute_next = min_rem[MinuteW-1:0];
        out_hour_next   = hour_rem[HourW-1:0];

        if (dim == 5'd0)
        begin
            // Month code not valid: pass date through untouched
            ok_next        = 1'b0;
            out_day_next   = day_reg;
            out_month_next = month_reg;
            out_year_next  = year_reg;
        end
        else
        begin
            ok_next        = 1'b1;
            out_day_next   = day_adj[DayW-1:0];
            out_month_next = month_adj;
            priority if (year_sum < $signed({2'b00, YearMin}))
            begin
                out_year_next = YearMin;
            end
            else if (year_sum > $signed({2'b00, YearMax}))
            begin
                out_year_next = YearMax;
            end
            else
            begin
                out_year_next = year_sum[YearW-1:0];
            end
        end
    end

    // Control state: valid flags and offsets
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            off_hours_reg   <= '0;
            off_minutes_reg <= '0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_OFFSET_HOURS)
                begin
                    off_hours_reg <= cfg_data[OffHoursW-1:0];
                end
                else if (cfg_index == REG_OFFSET_MINUTES)
                begin
                    off_minutes_reg <= cfg_data[OffMinW-1:0];
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            year_reg   <= in_year;
            month_reg  <= in_month;
            day_reg    <= in_day;
            hour_reg   <= in_hour;
            minute_reg <= in_minute;
        end
        if (advance && in_valid_reg)
        begin
            out_year_reg   <= out_year_next;
            out_month_reg  <= out_month_next;
            out_day_reg    <= out_day_next;
            out_hour_reg   <= out_hour_next;
            out_minute_reg <= out_minute_next;
            ok_reg         <= ok_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_year   = out_year_reg;
    assign out_month  = out_month_reg;
    assign out_day    = out_day_reg;
    assign out_hour   = out_hour_reg;
    assign out_minute = out_minute_reg;
    assign ok         = ok_reg;

endmodule

`default_nettype wire

>>> sv/ctoa_checker.sv
`default_nettype none

`include "calendar_time_offset_adjust_defines.svh"

module ctoa_checker
    import ctoa_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic [YearW-1:0]   out_year,
    input wire logic [MonthW-1:0]  out_month,
    input wire logic [DayW-1:0]    out_day,
    input wire logic [HourW-1:0]   out_hour,
    input wire logic [MinuteW-1:0] out_minute,
    input wire logic               ok
);

    // Hold a stalled result beat
    `CTOA_ASSERT_NEXT(a_out_valid_hold, clk, rst_n, out_valid && out_stall, out_valid, "out_valid dropped while stalled")
    `CTOA_ASSERT_NEXT(a_out_payload_hold, clk, rst_n, out_valid && out_stall, $stable(out_year) && $stable(out_month) && $stable(out_day) && $stable(out_hour) && $stable(out_minute) && $stable(ok), "stalled output beat changed")

    // Back-pressure only passes through from a stalled, full output
    `CTOA_ASSERT_SAME(a_stall_source, clk, rst_n, in_stall, out_valid && out_stall, "in_stall without a stalled output beat")

    // Time of day always normalized
    `CTOA_ASSERT_SAME(a_time_range, clk, rst_n, out_valid, out_hour <= 5'd23 && out_minute <= 6'd59, "hour or minute out of range")

    // A fully adjusted date is a legal, saturated date
    `CTOA_ASSERT_SAME(a_date_range, clk, rst_n, out_valid && ok, out_year >= YearMin && out_year <= YearMax && out_month >= 4'd1 && out_month <= 4'd12 && out_day >= 5'd1 && out_day <= 5'd31, "adjusted date out of range")

endmodule

bind calendar_time_offset_adjust ctoa_checker u_ctoa_checker (.*);

`default_nettype wire

>>> dv/calendar_time_offset_adjust_tb.sv
`timescale 1ns / 100ps

module calendar_time_offset_adjust_tb;
    import ctoa_pkg::*;

    // Index with no register behind it; a write there must change nothing
    localparam logic [CfgIdxW-1:0] REG_UNMAPPED = 2'd3;

    localparam int RandomBeats = 990;
    localparam int CycleLimit  = 300000;
    localparam int DrainCycles = 8;
    localparam int ResetCycles = 6;

    typedef struct packed {
        logic [YearW-1:0]   year;
        logic [MonthW-1:0]  month;
        logic [DayW-1:0]    day;
        logic [HourW-1:0]   hour;
        logic [MinuteW-1:0] minute;
    } stamp_t;

    typedef struct packed {
        logic [YearW-1:0]   year;
        logic [MonthW-1:0]  month;
        logic [DayW-1:0]    day;
        logic [HourW-1:0]   hour;
        logic [MinuteW-1:0] minute;
        logic               ok;
    } result_t;

    typedef struct packed {
        logic [CfgDataW-1:0] hours_data;
        logic [CfgDataW-1:0] minutes_data;
        stamp_t              stamp;
        bit                  known;
        result_t             want;
    } row_t;

    logic                clk;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_stall;
    logic [YearW-1:0]    in_year    = '0;
    logic [MonthW-1:0]   in_month   = '0;
    logic [DayW-1:0]     in_day     = '0;
    logic [HourW-1:0]    in_hour    = '0;
    logic [MinuteW-1:0]  in_minute  = '0;
    logic                out_valid;
    logic                out_stall  = 1'b0;
    logic [YearW-1:0]    out_year;
    logic [MonthW-1:0]   out_month;
    logic [DayW-1:0]     out_day;
    logic [HourW-1:0]    out_hour;
    logic [MinuteW-1:0]  out_minute;
    logic                ok;
    logic                cfg_valid  = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index  = '0;
    logic [CfgDataW-1:0] cfg_data   = '0;

    // Mirror of the offset registers as the block should hold them
    logic signed [OffHoursW-1:0] ofs_hours   = '0;
    logic signed [OffMinW-1:0]   ofs_minutes = '0;

    result_t adjusted_q[$];
    row_t    directed_rows[$];
    int      fail_count  = 0;
    int      cycle_count = 0;

    calendar_time_offset_adjust DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int div_floor(input int n, input int d);
        int q;
        q = n / d;
        if (n % d < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic int days_in_month(input int yr, input int mo);
        bit leap;
        leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
        case (mo)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    // Shift one timestamp by the mirrored offset
    function automatic result_t adjust_stamp(input stamp_t s);
        int mn, hr, dy, mo, yr, oh, om, sum, carry, dim, yr_lo, yr_hi;
        result_t r;
        mn    = s.minute;
        hr    = s.hour;
        dy    = s.day;
        mo    = s.month;
        yr    = s.year;
        oh    = ofs_hours;
        om    = ofs_minutes;
        yr_lo = YearMin;
        yr_hi = YearMax;

        // Split minute and hour sums by floor division
        sum   = mn + om;
        carry = div_floor(sum, 60);
        mn    = sum - carry * 60;
        sum   = hr + oh + carry;
        carry = div_floor(sum, 24);
        hr    = sum - carry * 24;

        // Ripple the day carry into month and year for a valid month only
        dim  = days_in_month(yr, mo);
        r.ok = (dim != 0);
        if (dim != 0)
        begin
            sum = dy + carry;
            if (sum < 1)
            begin
                dy = sum + days_in_month(yr, (mo == 1) ? 12 : mo - 1);
                mo = mo - 1;
            end
            else if (sum > dim)
            begin
                dy = sum - dim;
                mo = mo + 1;
            end
            else
                dy = sum;
            if (mo < 1)
            begin
                mo = 12;
                yr = yr - 1;
            end
            else if (mo > 12)
            begin
                mo = 1;
                yr = yr + 1;
            end
            if (yr < yr_lo)
                yr = yr_lo;
            if (yr > yr_hi)
                yr = yr_hi;
        end

        r.year   = YearW'(yr);
        r.month  = MonthW'(mo);
        r.day    = DayW'(dy);
        r.hour   = HourW'(hr);
        r.minute = MinuteW'(mn);
        return r;
    endfunction

    // Mostly well-formed timestamps leaning on the carry edges, some raw noise
    function automatic stamp_t random_stamp();
        stamp_t s;
        int     len;
        if ($urandom_range(0, 99) < 8)
        begin
            s.year   = YearW'($urandom_range(0, 32767));
            s.month  = MonthW'($urandom_range(0, 15));
            s.day    = DayW'($urandom_range(0, 31));
            s.hour   = HourW'($urandom_range(0, 31));
            s.minute = MinuteW'($urandom_range(0, 63));
            return s;
        end
        case ($urandom_range(0, 9))
            0:       s.year = YearW'($urandom_range(1601, 1605));
            1:       s.year = YearW'($urandom_range(30823, 30827));
            2:       s.year = YearW'(100 * $urandom_range(17, 308));
            3:       s.year = YearW'(4 * $urandom_range(401, 7706));
            default: s.year = YearW'($urandom_range(1601, 30827));
        endcase
        s.month = MonthW'($urandom_range(1, 12));
        len     = days_in_month(s.year, s.month);
        case ($urandom_range(0, 3))
            0:       s.day = DayW'(1);
            1:       s.day = DayW'(len);
            default: s.day = DayW'($urandom_range(1, len));
        endcase
        case ($urandom_range(0, 3))
            0:       s.hour = '0;
            1:       s.hour = HourW'(23);
            default: s.hour = HourW'($urandom_range(0, 23));
        endcase
        case ($urandom_range(0, 3))
            0:       s.minute = '0;
            1:       s.minute = MinuteW'(59);
            default: s.minute = MinuteW'($urandom_range(0, 59));
        endcase
        return s;
    endfunction

    task automatic add_row(input int oh, input int om, input stamp_t s);
        row_t r;
        r.hours_data   = CfgDataW'(oh);
        r.minutes_data = CfgDataW'(om);
        r.stamp        = s;
        r.known        = 1'b0;
        r.want         = '0;
        directed_rows.push_back(r);
    endtask

    task automatic add_known(input int oh, input int om, input stamp_t s, input result_t want);
        row_t r;
        r.hours_data   = CfgDataW'(oh);
        r.minutes_data = CfgDataW'(om);
        r.stamp        = s;
        r.known        = 1'b1;
        r.want         = want;
        directed_rows.push_back(r);
    endtask

    task automatic wait_idle();
        while (adjusted_q.size() != 0)
            @(posedge clk);
    endtask

    // Hold one config beat until taken, then update the mirror; caller drops valid
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_OFFSET_HOURS)
            ofs_hours = data[OffHoursW-1:0];
        else if (idx == REG_OFFSET_MINUTES)
            ofs_minutes = data[OffMinW-1:0];
    endtask

    task automatic set_offsets(input logic [CfgDataW-1:0] hours_data,
                               input logic [CfgDataW-1:0] minutes_data,
                               input bit with_unmapped);
        wait_idle();
        if ($urandom_range(0, 1) == 0)
        begin
            write_reg(REG_OFFSET_HOURS, hours_data);
            write_reg(REG_OFFSET_MINUTES, minutes_data);
        end
        else
        begin
            write_reg(REG_OFFSET_MINUTES, minutes_data);
            write_reg(REG_OFFSET_HOURS, hours_data);
        end
        if (with_unmapped)
            write_reg(REG_UNMAPPED, CfgDataW'($urandom_range(0, 127)));
        cfg_valid <= 1'b0;
    endtask

    // Hold one input beat until taken and queue its expected result; caller drops valid
    task automatic send_stamp(input stamp_t s, input bit known, input result_t want);
        in_valid  <= 1'b1;
        in_year   <= s.year;
        in_month  <= s.month;
        in_day    <= s.day;
        in_hour   <= s.hour;
        in_minute <= s.minute;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        adjusted_q.push_back(known ? want : adjust_stamp(s));
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (adjusted_q.size() == 0)
            begin
                $error("out: result beat with no expectation pending");
                fail_count++;
            end
            else
            begin
                want = adjusted_q.pop_front();
                check_field("out_year", 32'(want.year), 32'(out_year));
                check_field("out_month", 32'(want.month), 32'(out_month));
                check_field("out_day", 32'(want.day), 32'(out_day));
                check_field("out_hour", 32'(want.hour), 32'(out_hour));
                check_field("out_minute", 32'(want.minute), 32'(out_minute));
                check_field("ok", 32'(want.ok), 32'(ok));
            end
        end
    end

    // Stall the output in modes picked at random, one after another
    initial
    begin : stall_pattern
        int mode;
        int span;
        wait (rst_n);
        forever
        begin
            mode = $urandom_range(0, 4);
            span = $urandom_range(20, 200);
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 1) == 0);
                    3:       out_stall <= ($urandom_range(0, 9) != 0);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit)
        begin
            $display("calendar_time_offset_adjust_tb: errors");
            $finish;
        end
    end

    initial
    begin : stimulus
        int                  n;
        int                  total;
        int                  phase;
        int                  count;
        int                  burst_left;
        int                  mode;
        int                  oh;
        int                  om;
        logic [CfgDataW-1:0] hours_data;
        logic [CfgDataW-1:0] minutes_data;
        row_t                r;
        bit                  next_differs;

        // Zero offset straight after reset, then invalid months passing through
        add_known(0, 0, {15'd2024, 4'd3, 5'd15, 5'd10, 6'd30},
                  {15'd2024, 4'd3, 5'd15, 5'd10, 6'd30, 1'b1});
        add_known(0, 0, {15'd32767, 4'd0, 5'd31, 5'd23, 6'd59},
                  {15'd32767, 4'd0, 5'd31, 5'd23, 6'd59, 1'b0});
        add_known(0, 0, {15'd0, 4'd15, 5'd0, 5'd0, 6'd0},
                  {15'd0, 4'd15, 5'd0, 5'd0, 6'd0, 1'b0});
        add_row(0, 0, {15'd0, 4'd12, 5'd31, 5'd31, 6'd63});
        // Largest positive offset: year rollover, top saturation, leap rules
        add_known(23, 59, {15'd1999, 4'd12, 5'd31, 5'd23, 6'd59},
                  {15'd2000, 4'd1, 5'd1, 5'd23, 6'd58, 1'b1});
        add_known(23, 59, {15'd30827, 4'd12, 5'd31, 5'd23, 6'd59},
                  {15'd30827, 4'd1, 5'd1, 5'd23, 6'd58, 1'b1});
        add_row(23, 59, {15'd2000, 4'd2, 5'd28, 5'd23, 6'd59});
        add_row(23, 59, {15'd1900, 4'd2, 5'd28, 5'd23, 6'd59});
        add_row(23, 59, {15'd2004, 4'd2, 5'd28, 5'd23, 6'd59});
        add_row(23, 59, {15'd2003, 4'd2, 5'd28, 5'd23, 6'd59});
        add_row(23, 59, {15'd2001, 4'd4, 5'd30, 5'd12, 6'd0});
        add_row(23, 59, {15'd32767, 4'd6, 5'd15, 5'd0, 6'd0});
        // Largest negative offset: bottom saturation, borrow from February
        add_known(-23, -59, {15'd1601, 4'd1, 5'd1, 5'd0, 6'd0},
                  {15'd1601, 4'd12, 5'd31, 5'd0, 6'd1, 1'b1});
        add_row(-23, -59, {15'd2000, 4'd3, 5'd1, 5'd0, 6'd0});
        add_row(-23, -59, {15'd1900, 4'd3, 5'd1, 5'd0, 6'd0});
        add_row(-23, -59, {15'd0, 4'd6, 5'd15, 5'd12, 6'd30});
        add_row(-23, -59, {15'd5000, 4'd13, 5'd20, 5'd0, 6'd0});
        add_row(-23, -59, {15'd2021, 4'd5, 5'd0, 5'd23, 6'd59});
        // Register codes beyond the stated range give carries of two
        add_row(-32, -64, {15'd1601, 4'd1, 5'd1, 5'd0, 6'd0});
        add_row(-32, -64, {15'd2100, 4'd3, 5'd1, 5'd0, 6'd0});
        add_row(31, 63, {15'd30827, 4'd12, 5'd31, 5'd31, 6'd63});
        add_row(31, 63, {15'd2023, 4'd4, 5'd31, 5'd23, 6'd59});
        // Spare top data bit on the hours write is dropped
        add_row(64 + 5, -30, {15'd2024, 4'd7, 5'd10, 5'd8, 6'd15});

        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed rows back to back, reprogramming only between groups
        for (n = 0; n < directed_rows.size(); n++)
        begin
            r = directed_rows[n];
            if (n == 0 || r.hours_data != directed_rows[n-1].hours_data ||
                r.minutes_data != directed_rows[n-1].minutes_data)
                set_offsets(r.hours_data, r.minutes_data, n == 0);
            send_stamp(r.stamp, r.known, r.want);
            next_differs = (n == directed_rows.size() - 1) ||
                           (directed_rows[n+1].hours_data != r.hours_data) ||
                           (directed_rows[n+1].minutes_data != r.minutes_data);
            if (next_differs)
                in_valid <= 1'b0;
        end

        // Random phases, each drained before the next offset setting
        total = 0;
        phase = 0;
        while (total < RandomBeats)
        begin
            mode = (phase < 6) ? phase : $urandom_range(0, 11);
            case (mode)
                0: begin oh = 0;   om = 0;   end
                1: begin oh = 23;  om = 59;  end
                2: begin oh = -23; om = -59; end
                3: begin oh = 31;  om = 63;  end
                4: begin oh = -32; om = -64; end
                5: begin oh = $urandom_range(0, 127); om = $urandom_range(0, 127); end
                default:
                begin
                    oh = $urandom_range(0, 23);
                    om = $urandom_range(0, 59);
                    if ($urandom_range(0, 1) == 0)
                    begin
                        oh = -oh;
                        om = -om;
                    end
                end
            endcase
            hours_data               = CfgDataW'(oh);
            hours_data[CfgDataW-1]   = 1'($urandom_range(0, 1));
            minutes_data             = CfgDataW'(om);
            set_offsets(hours_data, minutes_data, $urandom_range(0, 5) == 0);

            count      = $urandom_range(40, 110);
            burst_left = 0;
            for (n = 0; n < count; n++)
            begin
                if (burst_left == 0)
                begin
                    burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(10, 60)
                                                             : $urandom_range(1, 4);
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                end
                send_stamp(random_stamp(), 1'b0, '0);
                burst_left--;
                if (burst_left == 0 || n == count - 1)
                    in_valid <= 1'b0;
            end
            total = total + count;
            phase++;
        end

        wait_idle();
        repeat (DrainCycles) @(posedge clk);
        if (fail_count == 0)
            $display("calendar_time_offset_adjust_tb: clean");
        else
            $display("calendar_time_offset_adjust_tb: errors");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/ctoa_pkg.sv
sv/calendar_time_offset_adjust.sv
sv/ctoa_checker.sv
dv/calendar_time_offset_adjust_tb.sv
